[hdl/mcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared widths, ALU operation codes and register-file write request type
// for the multicycle processor datapath.
// ----------------------------------------------------------------------------
package mcd_pkg;

	localparam int WORD_W    = 16;
	localparam int REG_COUNT = 16;
	localparam int REG_AW    = 4;
	localparam int MASK_W    = 5;

	localparam logic [REG_AW-1:0] REG_LINK = 4'd15;

	localparam int LD_A   = 0;
	localparam int LD_B   = 1;
	localparam int LD_RES = 2;
	localparam int LD_PC  = 3;
	localparam int LD_MDR = 4;

	typedef enum logic [3:0] {
		ALU_ADD    = 4'd0,
		ALU_SUB    = 4'd1,
		ALU_AND    = 4'd2,
		ALU_OR     = 4'd3,
		ALU_NOT    = 4'd4,
		ALU_SHL    = 4'd5,
		ALU_SHR    = 4'd6,
		ALU_IMM    = 4'd7,
		ALU_LDOFS  = 4'd8,
		ALU_STOFS  = 4'd9,
		ALU_PCINC  = 4'd10,
		ALU_BRANCH = 4'd11,
		ALU_JUMP   = 4'd12,
		ALU_PASSA  = 4'd13,
		ALU_PASSPC = 4'd14,
		ALU_ZERO   = 4'd15
	} alu_op_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [WORD_W-1:0] data;
	} rf_wr_t;

endpackage : mcd_pkg
`default_nettype wire

[hdl/mcd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_ram
// Generic RAM: one write port, two registered read ports, read before write.
// ----------------------------------------------------------------------------
module mcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata0,
	output logic      [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule : mcd_ram
`default_nettype wire

[hdl/mcd_regfile.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_regfile
// Register file on a RAM with reset-cleared valid bits. Reads are issued ahead
// of use from the next instruction; the write of the previous edge and
// the write of this cycle are forwarded.
// ----------------------------------------------------------------------------
module mcd_regfile
	import mcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rf_wr_t            wr,
	input  wire logic [REG_AW-1:0] ra_d,
	input  wire logic [REG_AW-1:0] rb_d,
	output logic      [WORD_W-1:0] a_val,
	output logic      [WORD_W-1:0] b_val
);

	logic [REG_COUNT-1:0] valid_q;
	logic [REG_AW-1:0]    ra_q;
	logic [REG_AW-1:0]    rb_q;
	logic                 va_q;
	logic                 vb_q;
	rf_wr_t               lw_q;
	logic [WORD_W-1:0]    rdata_a;
	logic [WORD_W-1:0]    rdata_b;
	logic [WORD_W-1:0]    stored_a;
	logic [WORD_W-1:0]    stored_b;

	mcd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (REG_COUNT)
	) u_ram (
		.clk    (clk),
		.we     (wr.en),
		.waddr  (wr.addr),
		.wdata  (wr.data),
		.raddr0 (ra_d),
		.raddr1 (rb_d),
		.rdata0 (rdata_a),
		.rdata1 (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ra_q    <= '0;
			rb_q    <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
			lw_q    <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			ra_q <= ra_d;
			rb_q <= rb_d;
			va_q <= valid_q[ra_d];
			vb_q <= valid_q[rb_d];
			lw_q <= wr;
		end
	end

	always_comb begin
		stored_a = (lw_q.en && lw_q.addr == ra_q) ? lw_q.data : (va_q ? rdata_a : '0);
		stored_b = (lw_q.en && lw_q.addr == rb_q) ? lw_q.data : (vb_q ? rdata_b : '0);
		a_val    = (wr.en && wr.addr == ra_q) ? wr.data : stored_a;
		b_val    = (wr.en && wr.addr == rb_q) ? wr.data : stored_b;
	end

endmodule : mcd_regfile
`default_nettype wire

[hdl/mcd_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_alu
// Sixteen-operation ALU on the A, B and PC registers and the instruction.
// ----------------------------------------------------------------------------
module mcd_alu
	import mcd_pkg::*;
(
	input  wire logic [3:0]        op,
	input  wire logic [WORD_W-1:0] a,
	input  wire logic [WORD_W-1:0] b,
	input  wire logic [WORD_W-1:0] pc,
	input  wire logic [WORD_W-1:0] ir,
	output logic      [WORD_W-1:0] res
);

	always_comb begin
		case (alu_op_t'(op))
			ALU_ADD:    res = a + b;
			ALU_SUB:    res = a - b;
			ALU_AND:    res = a & b;
			ALU_OR:     res = a | b;
			ALU_NOT:    res = ~a;
			ALU_SHL:    res = a << b[3:0];
			ALU_SHR:    res = a >> b[3:0];
			ALU_IMM:    res = {8'd0, ir[7:0]};
			ALU_LDOFS:  res = b + {12'd0, ir[7:4]};
			ALU_STOFS:  res = b + {12'd0, ir[11:8]};
			ALU_PCINC:  res = pc + 16'd1;
			ALU_BRANCH: res = pc + {{8{ir[11]}}, ir[11:4]};
			ALU_JUMP:   res = {pc[15:12], ir[11:0]};
			ALU_PASSA:  res = a;
			ALU_PASSPC: res = pc;
			ALU_ZERO:   res = '0;
			default:    res = '0;
		endcase
	end

endmodule : mcd_alu
`default_nettype wire

[hdl/multicycle_cpu_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multicycle_cpu_datapath
// 16-bit multicycle processor datapath driven by one control word per step.
//
// The slave channel carries one controller micro-step per request; the master
// channel returns the datapath outputs (address, store data, B flags, opcode)
// seen after that step, one result per request, in order.
// A request is captured in an input register and executed from there:
// writeback, ALU and register loads run in one pass of logic into the state
// and the output register, which then holds the result.
// Throughput is one request per cycle while the receiver takes results, set by the
// register-file read, ALU and load selection that form the single execution stage.
// Register-file reads are issued ahead of use from the next instruction word.
// Reset clears every register but the input control word, the register-file valid
// bits and both channels; the held output comes up with the zero flag set.
// When the receiver stalls the output register holds, a full input register
// holds behind it and s_tready drops; nothing executes until it drains.
// ----------------------------------------------------------------------------
module multicycle_cpu_datapath
	import mcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// hold, wb_en, dest_is_r15, write_from_mdr, alu_select[3:0],
	// load_mask[4:0], load_instruction, addr_from_result, mem_data_in[15:0]
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// mem_addr[15:0], store_data[15:0], b_is_zero, b_is_negative, opcode[3:0]
	output logic      [39:0] m_tdata
);

	typedef struct packed {
		logic              pad;
		logic [WORD_W-1:0] mem_data_in;
		logic              addr_from_result;
		logic              load_instruction;
		logic [MASK_W-1:0] load_mask;
		logic [3:0]        alu_select;
		logic              write_from_mdr;
		logic              dest_is_r15;
		logic              wb_en;
		logic              hold;
	} ctrl_t;

	typedef struct packed {
		logic [1:0]        pad;
		logic [3:0]        opcode;
		logic              b_is_negative;
		logic              b_is_zero;
		logic [WORD_W-1:0] store_data;
		logic [WORD_W-1:0] mem_addr;
	} out_item_t;

	ctrl_t             ctrl_s1;
	logic              valid_s1;
	logic              advance;
	logic              step;

	logic [WORD_W-1:0] pc_q, ir_q, a_q, b_q, res_q, mdr_q;
	logic [WORD_W-1:0] pc_n, ir_n, a_n, b_n, res_n, mdr_n;
	logic [WORD_W-1:0] ir_d;
	out_item_t         out_q, out_n;

	logic [WORD_W-1:0] alu_res;
	logic [WORD_W-1:0] rf_a, rf_b;
	rf_wr_t            rf_wr;

	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tdata  = out_q;

	always_comb begin
		rf_wr.en   = step && !ctrl_s1.hold && ctrl_s1.wb_en;
		rf_wr.addr = ctrl_s1.dest_is_r15 ? REG_LINK : ir_q[11:8];
		rf_wr.data = ctrl_s1.write_from_mdr ? mdr_q : res_q;
	end

	assign ir_d = step ? ir_n : ir_q;

	mcd_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rf_wr),
		.ra_d   (ir_d[7:4]),
		.rb_d   (ir_d[3:0]),
		.a_val  (rf_a),
		.b_val  (rf_b)
	);

	mcd_alu u_alu (
		.op  (ctrl_s1.alu_select),
		.a   (a_q),
		.b   (b_q),
		.pc  (pc_q),
		.ir  (ir_q),
		.res (alu_res)
	);

	always_comb begin
		pc_n  = pc_q;
		ir_n  = ir_q;
		a_n   = a_q;
		b_n   = b_q;
		res_n = res_q;
		mdr_n = mdr_q;
		out_n = out_q;
		if (!ctrl_s1.hold) begin
			if (ctrl_s1.load_mask[LD_A])   a_n   = rf_a;
			if (ctrl_s1.load_mask[LD_B])   b_n   = rf_b;
			if (ctrl_s1.load_mask[LD_RES]) res_n = alu_res;
			if (ctrl_s1.load_mask[LD_PC])  pc_n  = alu_res;
			if (ctrl_s1.load_mask[LD_MDR]) mdr_n = ctrl_s1.mem_data_in;
			out_n.mem_addr      = ctrl_s1.addr_from_result ? res_n : pc_n;
			out_n.store_data    = a_n;
			out_n.b_is_zero     = (b_n == '0);
			out_n.b_is_negative = b_n[WORD_W-1];
		end
		if (ctrl_s1.load_instruction) begin
			ir_n         = ctrl_s1.mem_data_in;
			a_n          = '0;
			b_n          = '0;
			res_n        = '0;
			mdr_n        = '0;
			out_n.opcode = ctrl_s1.mem_data_in[15:12];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ctrl_s1 <= ctrl_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
			pc_q     <= '0;
			ir_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			res_q    <= '0;
			mdr_q    <= '0;
			out_q    <= '{pad: '0, opcode: '0, b_is_negative: 1'b0, b_is_zero: 1'b1,
				store_data: '0, mem_addr: '0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_tvalid <= valid_s1;
			end
			if (step) begin
				pc_q  <= pc_n;
				ir_q  <= ir_n;
				a_q   <= a_n;
				b_q   <= b_n;
				res_q <= res_n;
				mdr_q <= mdr_n;
				out_q <= out_n;
			end
		end
	end

	a_ready_when_empty : assert property (
		@(posedge clk) disable iff (!arst_n) !valid_s1 |-> s_tready
	) else $error("input refused with empty input stage");

	a_stall_holds_stage : assert property (
		@(posedge clk) disable iff (!arst_n) (valid_s1 && !advance) |=> valid_s1
	) else $error("queued request dropped during stall");

	a_held_step_keeps_outputs : assert property (
		@(posedge clk) disable iff (!arst_n)
		(step && ctrl_s1.hold) |=> $stable(m_tdata[33:0])
	) else $error("held step changed datapath outputs");

	a_opcode_from_load : assert property (
		@(posedge clk) disable iff (!arst_n)
		(step && ctrl_s1.load_instruction) |=> (m_tdata[37:34] == $past(ctrl_s1.mem_data_in[15:12]))
	) else $error("opcode not taken from loaded instruction");

endmodule : multicycle_cpu_datapath
`default_nettype wire

[dv/mcd_step_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcd_step_checker
// Watches both stream channels of the multicycle datapath. For every accepted
// control word it steps its own copy of the registers and register file,
// queues the outputs that step should show, and compares each result that
// leaves the block against the oldest queued one.
// ----------------------------------------------------------------------------
module mcd_step_checker
	import mcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	output int               mismatches,
	output int               outstanding,
	output int               results_seen
);

	typedef struct packed {
		logic [WORD_W-1:0] mem_data_in;
		logic              addr_from_result;
		logic              load_instruction;
		logic [MASK_W-1:0] load_mask;
		alu_op_t           alu_select;
		logic              write_from_mdr;
		logic              dest_is_r15;
		logic              wb_en;
		logic              hold;
	} micro_step_t;

	typedef struct packed {
		logic [1:0]        pad;
		logic [3:0]        opcode;
		logic              b_is_negative;
		logic              b_is_zero;
		logic [WORD_W-1:0] store_data;
		logic [WORD_W-1:0] mem_addr;
	} dp_outputs_t;

	logic [WORD_W-1:0] pc, ir, op_a, op_b, result_reg, mdr;
	logic [WORD_W-1:0] regfile [REG_COUNT];
	dp_outputs_t       shown;
	dp_outputs_t       expected_outputs [$];

	function automatic logic [WORD_W-1:0] alu_calc(input alu_op_t op);
		case (op)
			ALU_ADD:    return op_a + op_b;
			ALU_SUB:    return op_a - op_b;
			ALU_AND:    return op_a & op_b;
			ALU_OR:     return op_a | op_b;
			ALU_NOT:    return ~op_a;
			ALU_SHL:    return op_a << op_b[3:0];
			ALU_SHR:    return op_a >> op_b[3:0];
			ALU_IMM:    return {8'h00, ir[7:0]};
			ALU_LDOFS:  return op_b + {12'h000, ir[7:4]};
			ALU_STOFS:  return op_b + {12'h000, ir[11:8]};
			ALU_PCINC:  return pc + 16'd1;
			ALU_BRANCH: return pc + {{8{ir[11]}}, ir[11:4]};
			ALU_JUMP:   return {pc[15:12], ir[11:0]};
			ALU_PASSA:  return op_a;
			ALU_PASSPC: return pc;
			default:    return '0;
		endcase
	endfunction

	task automatic advance_datapath(input micro_step_t c);
		logic [WORD_W-1:0] alu_out;
		logic [REG_AW-1:0] rd;
		if (!c.hold) begin
			if (c.wb_en) begin
				rd = c.dest_is_r15 ? REG_LINK : ir[11:8];
				regfile[rd] = c.write_from_mdr ? mdr : result_reg;
			end
			alu_out = alu_calc(c.alu_select);
			if (c.load_mask[LD_A])   op_a = regfile[ir[7:4]];
			if (c.load_mask[LD_B])   op_b = regfile[ir[3:0]];
			if (c.load_mask[LD_RES]) result_reg = alu_out;
			if (c.load_mask[LD_PC])  pc = alu_out;
			if (c.load_mask[LD_MDR]) mdr = c.mem_data_in;
			shown.mem_addr      = c.addr_from_result ? result_reg : pc;
			shown.store_data    = op_a;
			shown.b_is_zero     = (op_b == '0);
			shown.b_is_negative = op_b[WORD_W-1];
		end
		if (c.load_instruction) begin
			ir         = c.mem_data_in;
			op_a       = '0;
			op_b       = '0;
			result_reg = '0;
			mdr        = '0;
			shown.opcode = c.mem_data_in[15:12];
		end
		expected_outputs.push_back(shown);
	endtask

	task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d, %s: expected %h, got %h",
				results_seen, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dp_outputs_t want, got;
		if (!arst_n) begin
			pc = '0;
			ir = '0;
			op_a = '0;
			op_b = '0;
			result_reg = '0;
			mdr = '0;
			foreach (regfile[i]) regfile[i] = '0;
			shown = '0;
			shown.b_is_zero = 1'b1;
			expected_outputs.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_outputs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %h arrived with no request outstanding", m_tdata);
				end else begin
					want = expected_outputs.pop_front();
					if (got.mem_addr !== want.mem_addr)
						report("mem_addr", want.mem_addr, got.mem_addr);
					if (got.store_data !== want.store_data)
						report("store_data", want.store_data, got.store_data);
					if (got.b_is_zero !== want.b_is_zero)
						report("b_is_zero", 16'(want.b_is_zero), 16'(got.b_is_zero));
					if (got.b_is_negative !== want.b_is_negative)
						report("b_is_negative", 16'(want.b_is_negative),
							16'(got.b_is_negative));
					if (got.opcode !== want.opcode)
						report("opcode", 16'(want.opcode), 16'(got.opcode));
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				advance_datapath(micro_step_t'(s_tdata[30:0]));
			outstanding = expected_outputs.size();
		end
	end

endmodule : mcd_step_checker

[dv/multicycle_cpu_datapath_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multicycle_cpu_datapath_tb
// Drives controller micro-steps into the datapath: a directed walk through
// fetch, writeback, operand reads, every ALU operation and held steps, then
// random fetch/load/execute/writeback sequences mixed with random noise, with
// random stalls on both channels. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module multicycle_cpu_datapath_tb
	import mcd_pkg::*;
();

	localparam int STEP_TARGET = 1450;
	localparam int QUIET_FROM  = 1250;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	int mismatches, outstanding, results_seen;
	int requests_sent;
	int sequences_run;
	int cycles;
	bit quiet;

	multicycle_cpu_datapath dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mcd_step_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timed out after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: stall in random bursts, none once the run goes quiet.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			default: return WORD_W'($urandom());
		endcase
	endfunction

	// Enter and leave at a falling edge; valid stays high between back-to-back requests.
	task automatic issue(input logic hold, input logic wb_en, input logic dest_is_r15,
			input logic write_from_mdr, input alu_op_t alu, input logic [MASK_W-1:0] mask,
			input logic load_instruction, input logic addr_from_result,
			input logic [WORD_W-1:0] mem_data_in);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, mem_data_in, addr_from_result, load_instruction, mask, alu,
			write_from_mdr, dest_is_r15, wb_en, hold};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic issue_noise();
		issue($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), alu_op_t'($urandom_range(0, 15)),
			MASK_W'($urandom_range(0, 31)), $urandom_range(0, 9) == 0,
			1'($urandom_range(0, 1)), rand_word());
	endtask

	// Fetch, fill registers from memory, read operands, execute, write back.
	task automatic run_program_fragment();
		logic [MASK_W-1:0] mask;
		sequences_run++;
		issue($urandom_range(0, 5) == 0, 1'b0, 1'b0, 1'b0, ALU_PCINC,
			MASK_W'(1 << LD_PC), 1'b1, 1'($urandom_range(0, 1)), rand_word());
		repeat ($urandom_range(1, 3)) begin
			issue(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
				alu_op_t'($urandom_range(0, 15)), MASK_W'(1 << LD_MDR), 1'b0,
				1'($urandom_range(0, 1)), rand_word());
			issue(1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1,
				alu_op_t'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 3)), 1'b0,
				1'($urandom_range(0, 1)), rand_word());
		end
		repeat ($urandom_range(1, 4)) begin
			mask = MASK_W'($urandom_range(0, 31)) | MASK_W'(1 << LD_RES);
			issue($urandom_range(0, 11) == 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				alu_op_t'($urandom_range(0, 15)), mask, 1'b0,
				1'($urandom_range(0, 1)), rand_word());
		end
		issue(1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0, alu_op_t'($urandom_range(0, 15)),
			MASK_W'($urandom_range(0, 3)), 1'b0, 1'b1, rand_word());
	endtask

	initial begin
		int guard;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		quiet    = 1'b0;
		requests_sent = 0;
		sequences_run = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset outputs, fetch, writeback then operand read in one step.
		issue(1'b0, 1'b0, 1'b0, 1'b0, ALU_ZERO, '0, 1'b0, 1'b0, 16'h0000);
		issue(1'b0, 1'b0, 1'b0, 1'b0, ALU_PCINC, MASK_W'(1 << LD_PC), 1'b1, 1'b0, 16'h8223);
		issue(1'b0, 1'b0, 1'b0, 1'b0, ALU_ZERO, MASK_W'(1 << LD_MDR), 1'b0, 1'b0, 16'hFFFF);
		issue(1'b0, 1'b1, 1'b0, 1'b1, ALU_ZERO, MASK_W'(1 << LD_A), 1'b0, 1'b0, 16'h0000);
		issue(1'b0, 1'b0, 1'b0, 1'b0, ALU_ZERO, MASK_W'(1 << LD_MDR), 1'b0, 1'b0, 16'h8001);
		issue(1'b0, 1'b1, 1'b1, 1'b1, ALU_ZERO, '0, 1'b0, 1'b0, 16'h0000);
		// Held: all else set changes nothing; a held fetch still loads the instruction.
		issue(1'b1, 1'b1, 1'b1, 1'b1, ALU_PCINC, 5'b11111, 1'b0, 1'b1, 16'hFFFF);
		issue(1'b1, 1'b0, 1'b0, 1'b0, ALU_ZERO, '0, 1'b1, 1'b0, 16'h932F);
		issue(1'b0, 1'b0, 1'b0, 1'b0, ALU_ZERO, MASK_W'((1 << LD_A) | (1 << LD_B)), 1'b0,
			1'b0, 16'h0000);
		for (int op = 0; op < 16; op++)
			issue(1'b0, 1'b0, 1'b0, 1'b0, alu_op_t'(op), MASK_W'(1 << LD_RES), 1'b0, op[0],
				16'h0000);
		issue(1'b0, 1'b1, 1'b0, 1'b0, ALU_PASSPC, MASK_W'((1 << LD_PC) | (1 << LD_B)), 1'b0,
			1'b1, 16'h0000);
		// Unheld fetch with all loads: outputs show the values before the clear.
		issue(1'b0, 1'b1, 1'b1, 1'b0, ALU_BRANCH, 5'b11111, 1'b1, 1'b1, 16'h0F80);

		while (requests_sent < STEP_TARGET) begin
			if (requests_sent >= QUIET_FROM) quiet = 1'b1;
			if ($urandom_range(0, 9) < 7)
				run_program_fragment();
			else
				repeat ($urandom_range(1, 4)) issue_noise();
		end
		s_tvalid <= 1'b0;

		guard = 0;
		while (outstanding != 0 && guard < 10000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);

		$display("%0d micro-steps sent (%0d program fragments), %0d results checked",
			requests_sent, sequences_run, results_seen);
		$display("covered all ALU operations, held steps, fetch clears and writebacks");
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule : multicycle_cpu_datapath_tb

[multicycle_cpu_datapath.f]
hdl/mcd_pkg.sv
hdl/mcd_ram.sv
hdl/mcd_regfile.sv
hdl/mcd_alu.sv
hdl/multicycle_cpu_datapath.sv
dv/mcd_step_checker.sv
dv/multicycle_cpu_datapath_tb.sv
